>>> hdl/mrt_pkg.sv
// Package: shared types and constants of the mesh route table.
package mrt_pkg;

    localparam int ROUTE_SLOTS = 16;
    localparam int SLOT_W      = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
    localparam int CNT_W       = $clog2(ROUTE_SLOTS + 1);

    localparam logic [2:0] CMD_UPDATE  = 3'd0;
    localparam logic [2:0] CMD_LOOKUP  = 3'd1;
    localparam logic [2:0] CMD_REQUEST = 3'd2;
    localparam logic [2:0] CMD_RELEASE = 3'd3;
    localparam logic [2:0] CMD_REMOVE  = 3'd4;
    localparam logic [2:0] CMD_SCAN    = 3'd5;

    localparam logic [3:0] K_CREATED  = 4'd0;
    localparam logic [3:0] K_REPLACED = 4'd1;
    localparam logic [3:0] K_IGNORED  = 4'd2;
    localparam logic [3:0] K_FULL     = 4'd3;
    localparam logic [3:0] K_HIT      = 4'd4;
    localparam logic [3:0] K_MISS     = 4'd5;
    localparam logic [3:0] K_REQUEST  = 4'd6;
    localparam logic [3:0] K_RELEASED = 4'd7;
    localparam logic [3:0] K_REMOVED  = 4'd8;
    localparam logic [3:0] K_NOTFOUND = 4'd9;
    localparam logic [3:0] K_DELETED  = 4'd10;
    localparam logic [3:0] K_SCANDONE = 4'd11;

    localparam logic [1:0] REG_LIFETIME = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_RETRIES  = 2'd2;
    localparam logic [1:0] REG_NOROUTE  = 2'd3;

    typedef struct packed {
        logic        valid;
        logic        running;
        logic [15:0] dest;
        logic [3:0]  radio;
        logic [7:0]  metric;
        logic [15:0] next_hop;
        logic [15:0] origin;
        logic [15:0] seq_num;
        logic [7:0]  flags;
        logic [15:0] life;
        logic [7:0]  req_left;
        logic [7:0]  retries;
    } t_entry;

    // one cell's view of the current request
    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] dest;
        logic [3:0]  radio;
        logic [7:0]  metric;
        logic [15:0] next_hop;
        logic [15:0] origin;
        logic [15:0] seq_num;
        logic [7:0]  flags;
    } t_req;

    // control from the sequencer, shared by every cell
    typedef struct packed {
        logic shift;   // rotate the ring one slot
        logic tick;    // one second passes (scan, first lap)
        logic act;     // head cell applies the request
        logic scan;    // head cell applies scan expiry
        logic create;  // head cell is the target free slot
        logic [15:0] lifetime;
        logic [7:0]  timeout;
        logic [7:0]  retries;
    } t_ctl;

endpackage

>>> hdl/mrt_cell.sv
// Route cell: one table slot in a rotating ring; the head cell applies commands.
module mrt_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mrt_pkg::t_ctl        i_ctl,
    input  logic                 i_head,
    input  mrt_pkg::t_req        i_req,
    input  mrt_pkg::t_entry      i_prev,
    output mrt_pkg::t_entry      o_entry
);
    mrt_pkg::t_entry r_e, n_e, w_e;

    assign o_entry = r_e;

    always_comb begin
        w_e = i_ctl.shift ? i_prev : r_e;
        n_e = w_e;
        if (i_head && i_ctl.tick) begin
            if (w_e.valid && w_e.life != 16'd0) n_e.life = w_e.life - 16'd1;
            if (w_e.running && w_e.req_left != 8'd0) n_e.req_left = w_e.req_left - 8'd1;
        end
        if (i_head && i_ctl.act) begin
            unique case (i_req.cmd)
                mrt_pkg::CMD_UPDATE: begin
                    if (i_ctl.create) begin
                        n_e.valid = 1'b1;
                        n_e.running = 1'b0;
                        n_e.req_left = 8'd0;
                        n_e.retries = 8'd0;
                    end
                    n_e.life = i_ctl.lifetime;
                    if (i_ctl.create || !(w_e.origin == i_req.origin &&
                            w_e.seq_num == i_req.seq_num &&
                            w_e.metric <= i_req.metric)) begin
                        n_e.dest = i_req.dest;
                        n_e.radio = i_req.radio;
                        n_e.metric = i_req.metric;
                        n_e.next_hop = i_req.next_hop;
                        n_e.origin = i_req.origin;
                        n_e.seq_num = i_req.seq_num;
                        n_e.flags = i_req.flags;
                    end
                end
                mrt_pkg::CMD_LOOKUP: n_e.life = i_ctl.lifetime;
                mrt_pkg::CMD_REQUEST: begin
                    n_e.retries = i_ctl.retries;
                    n_e.req_left = i_ctl.timeout;
                    n_e.running = 1'b1;
                end
                mrt_pkg::CMD_RELEASE: n_e.running = 1'b0;
                mrt_pkg::CMD_REMOVE: begin
                    n_e.valid = 1'b0;
                    n_e.running = 1'b0;
                end
                default: ;
            endcase
        end
        if (i_head && i_ctl.scan && w_e.valid) begin
            if (w_e.running && w_e.req_left == 8'd0) begin
                if (w_e.retries != 8'd0) begin
                    n_e.retries = w_e.retries - 8'd1;
                    n_e.req_left = i_ctl.timeout;
                end else begin
                    n_e.valid = 1'b0;
                    n_e.running = 1'b0;
                end
            end
            if (w_e.life == 16'd0) begin
                n_e.valid = 1'b0;
                n_e.running = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
        if (!i_rst_n) begin
            r_e.valid <= 1'b0;
            r_e.running <= 1'b0;
        end
    end
endmodule

>>> hdl/mesh_route_table.sv
// Top level: mesh route table built as a rotating ring of route cells.
//  channel  | signals                              | direction
//  command  | i_start, o_busy, i_command..fields  | in
//  result   | o_valid, o_kind..o_last              | out, no stall
//  config   | i_cfg_we, i_cfg_index, i_cfg_data    | in
// Every command up to CMD_SCAN rotates the ring of ROUTE_SLOTS cells through two laps,
// one slot per cycle: a find lap (a scan also counts timers down) and an act lap in
// which the entry passing the head is examined and updated. busy stays high through
// both laps and a done state; a command is taken only while busy is low.
// A scan slot that re-sends a request and also expires gives its deleted result
// in the cycle after its request result, possibly just after busy falls.
// Synchronous reset clears valid and running bits. Results cannot be stalled.
module mesh_route_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_dest,
    input  logic [3:0]  i_radio,
    input  logic [7:0]  i_metric,
    input  logic [15:0] i_next_hop,
    input  logic [15:0] i_origin,
    input  logic [15:0] i_sequence_req,
    input  logic [7:0]  i_route_flags,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [3:0]  o_kind,
    output logic [15:0] o_dest_res,
    output logic [7:0]  o_metric_res,
    output logic [15:0] o_next_hop_res,
    output logic [3:0]  o_radio_res,
    output logic [7:0]  o_route_flags_res,
    output logic        o_last
);
    localparam int N = mrt_pkg::ROUTE_SLOTS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FIND = 4'b0010,
        S_ACT  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [15:0] r_life;
    logic [7:0]  r_tmo, r_retr, r_nrm;
    mrt_pkg::t_req r_req;
    logic [mrt_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic r_hit, r_free, r_stop;
    logic r_dpend;
    logic [mrt_pkg::SLOT_W-1:0] r_tgt;
    logic r_ov;
    logic [3:0] r_k;
    logic [15:0] r_d, r_nh;
    logic [7:0] r_m, r_f;
    logic [3:0] r_r;
    logic r_l;

    mrt_pkg::t_entry w_ent [N];
    mrt_pkg::t_ctl   w_ctl;
    mrt_pkg::t_entry h;
    logic [mrt_pkg::SLOT_W-1:0] w_pos;
    logic w_at;
    logic w_match;

    assign h = w_ent[0];
    assign w_pos = r_cnt[mrt_pkg::SLOT_W-1:0];
    assign w_at = (w_pos == r_tgt);
    assign w_match = h.valid && h.dest == r_req.dest;
    assign o_busy = (r_state != S_IDLE);

    // the last cell takes the head entry as it rotates and applies the changes
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            mrt_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_ctl),
                .i_head (g == N - 1),
                .i_req  (r_req),
                .i_prev (w_ent[(g + 1) % N]),
                .o_entry(w_ent[g])
            );
        end
    endgenerate

    // evaluate scan expiry on the head entry as it enters the head cell in the act lap
    logic w_exp_req, w_del;
    always_comb begin
        w_exp_req = h.valid && h.running && h.req_left == 8'd0 && h.retries != 8'd0;
        w_del = h.valid && ((h.running && h.req_left == 8'd0 && h.retries == 8'd0)
                || h.life == 16'd0);
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        w_ctl = '0;
        w_ctl.lifetime = r_life;
        w_ctl.timeout = r_tmo;
        w_ctl.retries = r_retr;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_command <= mrt_pkg::CMD_SCAN) begin
                    n_state = S_FIND;
                    n_cnt = '0;
                end
            end
            S_FIND: begin
                w_ctl.shift = 1'b1;
                w_ctl.tick = (r_req.cmd == mrt_pkg::CMD_SCAN);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == mrt_pkg::CNT_W'(N - 1)) begin
                    n_cnt = '0;
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                w_ctl.shift = 1'b1;
                w_ctl.act = w_at && (r_hit || (r_req.cmd == mrt_pkg::CMD_UPDATE && r_free));
                w_ctl.create = !r_hit;
                w_ctl.scan = (r_req.cmd == mrt_pkg::CMD_SCAN) && !r_stop;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == mrt_pkg::CNT_W'(N - 1)) n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_life <= 16'd300;
            r_tmo <= 8'd5;
            r_retr <= 8'd3;
            r_nrm <= 8'd255;
            r_ov <= 1'b0;
            r_hit <= 1'b0;
            r_free <= 1'b0;
            r_stop <= 1'b0;
            r_dpend <= 1'b0;
            r_tgt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_ov <= 1'b0;
            // deleted result after a re-sent request of the same slot
            if (r_dpend) begin
                r_ov <= 1'b1;
                r_k <= mrt_pkg::K_DELETED;
                r_l <= 1'b1;
                r_dpend <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mrt_pkg::REG_LIFETIME: r_life <= i_cfg_data;
                    mrt_pkg::REG_TIMEOUT:  r_tmo <= i_cfg_data[7:0];
                    mrt_pkg::REG_RETRIES:  r_retr <= i_cfg_data[7:0];
                    mrt_pkg::REG_NOROUTE:  r_nrm <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    r_hit <= 1'b0;
                    r_free <= 1'b0;
                    r_stop <= 1'b0;
                    if (i_start) begin
                        r_req.cmd <= i_command;
                        r_req.dest <= i_dest;
                        r_req.radio <= i_radio;
                        r_req.metric <= i_metric;
                        r_req.next_hop <= i_next_hop;
                        r_req.origin <= i_origin;
                        r_req.seq_num <= i_sequence_req;
                        r_req.flags <= i_route_flags;
                    end
                end
                S_FIND: begin
                    if (w_match && !r_hit) begin
                        r_hit <= 1'b1;
                        r_tgt <= w_pos;
                    end else if (!h.valid && !r_hit && !r_free) begin
                        r_free <= 1'b1;
                        r_tgt <= w_pos;
                    end
                end
                S_ACT: begin
                    if (w_at && r_req.cmd != mrt_pkg::CMD_SCAN &&
                            (r_hit || (r_req.cmd == mrt_pkg::CMD_UPDATE && r_free))) begin
                        r_ov <= 1'b1;
                        r_l <= 1'b1;
                        r_d <= r_req.dest;
                        r_m <= h.metric; r_nh <= h.next_hop;
                        r_r <= h.radio; r_f <= h.flags;
                        unique case (r_req.cmd)
                            mrt_pkg::CMD_UPDATE: begin
                                if (!r_hit) r_k <= mrt_pkg::K_CREATED;
                                else if (h.origin == r_req.origin &&
                                        h.seq_num == r_req.seq_num &&
                                        h.metric <= r_req.metric)
                                    r_k <= mrt_pkg::K_IGNORED;
                                else r_k <= mrt_pkg::K_REPLACED;
                                if (!r_hit || !(h.origin == r_req.origin &&
                                        h.seq_num == r_req.seq_num &&
                                        h.metric <= r_req.metric)) begin
                                    r_m <= r_req.metric; r_nh <= r_req.next_hop;
                                    r_r <= r_req.radio; r_f <= r_req.flags;
                                end
                            end
                            mrt_pkg::CMD_LOOKUP:  r_k <= mrt_pkg::K_HIT;
                            mrt_pkg::CMD_REQUEST: r_k <= mrt_pkg::K_REQUEST;
                            mrt_pkg::CMD_RELEASE: r_k <= mrt_pkg::K_RELEASED;
                            default:              r_k <= mrt_pkg::K_REMOVED;
                        endcase
                    end
                    if (r_req.cmd == mrt_pkg::CMD_SCAN && !r_stop && (w_exp_req || w_del)) begin
                        r_ov <= 1'b1;
                        r_d <= h.dest; r_m <= h.metric; r_nh <= h.next_hop;
                        r_r <= h.radio; r_f <= h.flags;
                        r_k <= w_exp_req ? mrt_pkg::K_REQUEST : mrt_pkg::K_DELETED;
                        r_l <= !w_exp_req;
                        if (w_del) r_stop <= 1'b1;
                        if (w_exp_req && w_del) r_dpend <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (!(r_req.cmd == mrt_pkg::CMD_SCAN && r_stop) &&
                            !(r_req.cmd != mrt_pkg::CMD_SCAN &&
                              (r_hit || (r_req.cmd == mrt_pkg::CMD_UPDATE && r_free)))) begin
                        r_ov <= 1'b1;
                        r_l <= 1'b1;
                        r_d <= r_req.dest;
                        r_m <= 8'd0; r_nh <= 16'd0; r_r <= 4'd0; r_f <= 8'd0;
                        unique case (r_req.cmd)
                            mrt_pkg::CMD_UPDATE: r_k <= mrt_pkg::K_FULL;
                            mrt_pkg::CMD_LOOKUP: begin
                                r_k <= mrt_pkg::K_MISS;
                                r_m <= r_nrm;
                            end
                            mrt_pkg::CMD_SCAN: begin
                                r_k <= mrt_pkg::K_SCANDONE;
                                r_d <= 16'd0;
                            end
                            default: r_k <= mrt_pkg::K_NOTFOUND;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_kind = r_k;
    assign o_dest_res = r_d;
    assign o_metric_res = r_m;
    assign o_next_hop_res = r_nh;
    assign o_radio_res = r_r;
    assign o_route_flags_res = r_f;
    assign o_last = r_l;
endmodule

>>> tb/mesh_route_table_test.sv
// Testbench of mesh_route_table: random and directed commands checked against a route predictor.
`timescale 1ns / 1ps

module mesh_route_table_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_N      = 20;

    typedef struct {
        logic [2:0]  cmd;
        logic [15:0] dest;
        logic [3:0]  radio;
        logic [7:0]  metric;
        logic [15:0] next_hop;
        logic [15:0] origin;
        logic [15:0] seq;
        logic [7:0]  flags;
    } t_route_cmd;

    typedef struct {
        logic [3:0]  kind;
        logic [15:0] dest;
        logic [7:0]  metric;
        logic [15:0] next_hop;
        logic [3:0]  radio;
        logic [7:0]  flags;
        logic        last;
    } t_route_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [2:0]  i_command = '0;
    logic [15:0] i_dest = '0;
    logic [3:0]  i_radio = '0;
    logic [7:0]  i_metric = '0;
    logic [15:0] i_next_hop = '0;
    logic [15:0] i_origin = '0;
    logic [15:0] i_sequence_req = '0;
    logic [7:0]  i_route_flags = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_busy, o_valid, o_last;
    logic [3:0]  o_kind, o_radio_res;
    logic [15:0] o_dest_res, o_next_hop_res;
    logic [7:0]  o_metric_res, o_route_flags_res;

    mesh_route_table dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted table
    logic        t_valid [mrt_pkg::ROUTE_SLOTS];
    logic        t_run   [mrt_pkg::ROUTE_SLOTS];
    logic [15:0] t_dest  [mrt_pkg::ROUTE_SLOTS];
    logic [3:0]  t_radio [mrt_pkg::ROUTE_SLOTS];
    logic [7:0]  t_metric[mrt_pkg::ROUTE_SLOTS];
    logic [15:0] t_nh    [mrt_pkg::ROUTE_SLOTS];
    logic [15:0] t_org   [mrt_pkg::ROUTE_SLOTS];
    logic [15:0] t_seq   [mrt_pkg::ROUTE_SLOTS];
    logic [7:0]  t_flags [mrt_pkg::ROUTE_SLOTS];
    logic [15:0] t_life  [mrt_pkg::ROUTE_SLOTS];
    logic [7:0]  t_reqt  [mrt_pkg::ROUTE_SLOTS];
    logic [7:0]  t_retry [mrt_pkg::ROUTE_SLOTS];
    logic [15:0] cfg_life = 16'd300;
    logic [7:0]  cfg_timeout = 8'd5;
    logic [7:0]  cfg_retries = 8'd3;
    logic [7:0]  cfg_noroute = 8'd255;

    t_route_cmd    pending_cmds[$];
    t_route_result expected_results[$];
    t_route_cmd    cur_cmd;
    int idle_pct = 27;
    int errors = 0;
    int accepted = 0;
    int checked = 0;
    int cycles = 0;
    logic [15:0] pool [POOL_N];
    logic [15:0] adv_org [POOL_N];
    logic [15:0] adv_seq [POOL_N];
    logic        adv_have[POOL_N];

    initial begin
        for (int s = 0; s < mrt_pkg::ROUTE_SLOTS; s++) begin
            t_valid[s] = 1'b0;
            t_run[s] = 1'b0;
        end
    end

    task automatic push_result(logic [3:0] k, logic [15:0] d, logic [7:0] m,
                               logic [15:0] nh, logic [3:0] r, logic [7:0] f,
                               logic l);
        t_route_result e;
        e.kind = k; e.dest = d; e.metric = m; e.next_hop = nh;
        e.radio = r; e.flags = f; e.last = l;
        expected_results.push_back(e);
    endtask

    task automatic push_slot(logic [3:0] k, int s, logic l);
        push_result(k, t_dest[s], t_metric[s], t_nh[s], t_radio[s], t_flags[s], l);
    endtask

    task automatic predict_routes(t_route_cmd q);
        int hit;
        int s;
        logic [3:0] k;
        hit = -1;
        if (q.cmd > mrt_pkg::CMD_SCAN) return;
        if (q.cmd != mrt_pkg::CMD_SCAN)
            for (s = mrt_pkg::ROUTE_SLOTS - 1; s >= 0; s--)
                if (t_valid[s] && t_dest[s] == q.dest) hit = s;
        if (q.cmd == mrt_pkg::CMD_UPDATE) begin
            if (hit < 0) begin
                for (s = 0; s < mrt_pkg::ROUTE_SLOTS; s++)
                    if (!t_valid[s]) break;
                if (s == mrt_pkg::ROUTE_SLOTS) begin
                    push_result(mrt_pkg::K_FULL, q.dest, '0, '0, '0, '0, 1'b1);
                    return;
                end
                t_valid[s] = 1'b1;
                t_run[s] = 1'b0;
                t_retry[s] = '0;
                t_reqt[s] = '0;
                k = mrt_pkg::K_CREATED;
            end else begin
                s = hit;
                t_life[s] = cfg_life;
                if (t_org[s] == q.origin && t_seq[s] == q.seq && t_metric[s] <= q.metric) begin
                    push_slot(mrt_pkg::K_IGNORED, s, 1'b1);
                    return;
                end
                k = mrt_pkg::K_REPLACED;
            end
            t_dest[s] = q.dest; t_radio[s] = q.radio; t_metric[s] = q.metric;
            t_nh[s] = q.next_hop; t_org[s] = q.origin; t_seq[s] = q.seq;
            t_flags[s] = q.flags; t_life[s] = cfg_life;
            push_slot(k, s, 1'b1);
        end else if (q.cmd == mrt_pkg::CMD_LOOKUP) begin
            if (hit < 0) push_result(mrt_pkg::K_MISS, q.dest, cfg_noroute, '0, '0, '0, 1'b1);
            else begin
                t_life[hit] = cfg_life;
                push_slot(mrt_pkg::K_HIT, hit, 1'b1);
            end
        end else if (q.cmd != mrt_pkg::CMD_SCAN) begin
            if (hit < 0) push_result(mrt_pkg::K_NOTFOUND, q.dest, '0, '0, '0, '0, 1'b1);
            else if (q.cmd == mrt_pkg::CMD_REQUEST) begin
                t_retry[hit] = cfg_retries;
                t_reqt[hit] = cfg_timeout;
                t_run[hit] = 1'b1;
                push_slot(mrt_pkg::K_REQUEST, hit, 1'b1);
            end else if (q.cmd == mrt_pkg::CMD_RELEASE) begin
                t_run[hit] = 1'b0;
                push_slot(mrt_pkg::K_RELEASED, hit, 1'b1);
            end else begin
                t_valid[hit] = 1'b0;
                t_run[hit] = 1'b0;
                push_slot(mrt_pkg::K_REMOVED, hit, 1'b1);
            end
        end else begin
            for (s = 0; s < mrt_pkg::ROUTE_SLOTS; s++) begin
                if (t_valid[s] && t_life[s] != 0) t_life[s]--;
                if (t_run[s] && t_reqt[s] != 0) t_reqt[s]--;
            end
            for (s = 0; s < mrt_pkg::ROUTE_SLOTS; s++) begin
                if (!t_valid[s]) continue;
                if (t_run[s] && t_reqt[s] == 0) begin
                    if (t_retry[s] != 0) begin
                        t_retry[s]--;
                        t_reqt[s] = cfg_timeout;
                        push_slot(mrt_pkg::K_REQUEST, s, 1'b0);
                    end else begin
                        t_valid[s] = 1'b0;
                        t_run[s] = 1'b0;
                        push_slot(mrt_pkg::K_DELETED, s, 1'b1);
                        return;
                    end
                end
                if (t_life[s] == 0) begin
                    t_valid[s] = 1'b0;
                    t_run[s] = 1'b0;
                    push_slot(mrt_pkg::K_DELETED, s, 1'b1);
                    return;
                end
            end
            push_result(mrt_pkg::K_SCANDONE, '0, '0, '0, '0, '0, 1'b1);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        logic holding;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            holding = i_start;
            if (i_start && !o_busy) begin
                predict_routes(cur_cmd);
                accepted++;
                holding = 1'b0;
            end
            if (!holding) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_cmd = pending_cmds.pop_front();
                    i_command <= cur_cmd.cmd;
                    i_dest <= cur_cmd.dest;
                    i_radio <= cur_cmd.radio;
                    i_metric <= cur_cmd.metric;
                    i_next_hop <= cur_cmd.next_hop;
                    i_origin <= cur_cmd.origin;
                    i_sequence_req <= cur_cmd.seq;
                    i_route_flags <= cur_cmd.flags;
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_route_result e;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result kind %0d dest %h", o_kind, o_dest_res);
            end else begin
                e = expected_results.pop_front();
                checked++;
                if ({o_kind, o_dest_res, o_metric_res, o_next_hop_res, o_radio_res,
                     o_route_flags_res, o_last} !==
                    {e.kind, e.dest, e.metric, e.next_hop, e.radio, e.flags, e.last}) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp k%0d d%h m%h nh%h r%h f%h l%b got k%0d d%h m%h nh%h r%h f%h l%b",
                                 e.kind, e.dest, e.metric, e.next_hop, e.radio, e.flags, e.last,
                                 o_kind, o_dest_res, o_metric_res, o_next_hop_res,
                                 o_radio_res, o_route_flags_res, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_cmd(logic [2:0] c, logic [15:0] d, logic [3:0] r, logic [7:0] m,
                           logic [15:0] nh, logic [15:0] o, logic [15:0] sq, logic [7:0] f);
        t_route_cmd q;
        q.cmd = c; q.dest = d; q.radio = r; q.metric = m;
        q.next_hop = nh; q.origin = o; q.seq = sq; q.flags = f;
        pending_cmds.push_back(q);
    endtask

    task automatic add_random(int n);
        int r, p;
        logic [2:0] c;
        logic [15:0] d, o, sq;
        repeat (n) begin
            r = $urandom_range(99);
            p = $urandom_range(POOL_N - 1);
            d = ($urandom_range(9) == 0) ? 16'($urandom) : pool[p];
            o = 16'($urandom);
            sq = 16'($urandom);
            if (r < 35) c = mrt_pkg::CMD_UPDATE;
            else if (r < 55) c = mrt_pkg::CMD_LOOKUP;
            else if (r < 65) c = mrt_pkg::CMD_REQUEST;
            else if (r < 72) c = mrt_pkg::CMD_RELEASE;
            else if (r < 78) c = mrt_pkg::CMD_REMOVE;
            else if (r < 96) c = mrt_pkg::CMD_SCAN;
            else c = 3'($urandom_range(7, 6));
            if (c == mrt_pkg::CMD_UPDATE && d == pool[p]) begin
                if (adv_have[p] && $urandom_range(2) == 0) begin
                    o = adv_org[p];
                    sq = adv_seq[p];
                end
                adv_org[p] = o;
                adv_seq[p] = sq;
                adv_have[p] = 1'b1;
            end
            add_cmd(c, d, 4'($urandom), 8'($urandom), 16'($urandom), o, sq, 8'($urandom));
        end
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_cmds.size() != 0 || i_start || o_busy || expected_results.size() != 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            mrt_pkg::REG_LIFETIME: cfg_life = val;
            mrt_pkg::REG_TIMEOUT:  cfg_timeout = val[7:0];
            mrt_pkg::REG_RETRIES:  cfg_retries = val[7:0];
            default:               cfg_noroute = val[7:0];
        endcase
    endtask

    task automatic set_regs(logic [15:0] lf, logic [7:0] to, logic [7:0] rt, logic [7:0] nr);
        write_reg(mrt_pkg::REG_LIFETIME, lf);
        write_reg(mrt_pkg::REG_TIMEOUT, {8'd0, to});
        write_reg(mrt_pkg::REG_RETRIES, {8'd0, rt});
        write_reg(mrt_pkg::REG_NOROUTE, {8'd0, nr});
    endtask

    initial begin
        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;
        for (int i = 0; i < POOL_N; i++) begin
            if (i > 1) pool[i] = 16'($urandom);
            adv_have[i] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_regs(16'd3, 8'd1, 8'd0, 8'd0);

        // directed: extremes, duplicates, misses, unknown commands, releases, removes and scans
        add_cmd(mrt_pkg::CMD_UPDATE, 16'h0000, 4'h0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00);
        add_cmd(mrt_pkg::CMD_UPDATE, 16'hFFFF, 4'hF, 8'h80, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        add_cmd(mrt_pkg::CMD_UPDATE, 16'hFFFF, 4'h1, 8'hFF, 16'h1234, 16'hFFFF, 16'hFFFF, 8'h11);
        add_cmd(mrt_pkg::CMD_UPDATE, 16'hFFFF, 4'h2, 8'h10, 16'h4321, 16'hFFFF, 16'hFFFF, 8'h22);
        add_cmd(mrt_pkg::CMD_LOOKUP, 16'hFFFF, '0, '0, '0, '0, '0, '0);
        add_cmd(mrt_pkg::CMD_LOOKUP, 16'h5555, '0, '0, '0, '0, '0, '0);
        add_cmd(mrt_pkg::CMD_REQUEST, 16'h0000, '0, '0, '0, '0, '0, '0);
        add_cmd(mrt_pkg::CMD_REQUEST, 16'h0000, '0, '0, '0, '0, '0, '0);
        add_cmd(mrt_pkg::CMD_REQUEST, 16'h5555, '0, '0, '0, '0, '0, '0);
        add_cmd(mrt_pkg::CMD_RELEASE, 16'h5555, '0, '0, '0, '0, '0, '0);
        add_cmd(mrt_pkg::CMD_REMOVE, 16'h5555, '0, '0, '0, '0, '0, '0);
        add_cmd(3'd6, 16'h0000, '0, '0, '0, '0, '0, '0);
        add_cmd(3'd7, 16'hFFFF, '0, '0, '0, '0, '0, '0);
        add_cmd(mrt_pkg::CMD_SCAN, '0, '0, '0, '0, '0, '0, '0);
        add_cmd(mrt_pkg::CMD_RELEASE, 16'hFFFF, '0, '0, '0, '0, '0, '0);
        add_cmd(mrt_pkg::CMD_SCAN, '0, '0, '0, '0, '0, '0, '0);
        add_cmd(mrt_pkg::CMD_REMOVE, 16'hFFFF, '0, '0, '0, '0, '0, '0);
        add_cmd(mrt_pkg::CMD_SCAN, '0, '0, '0, '0, '0, '0, '0);
        add_cmd(mrt_pkg::CMD_SCAN, '0, '0, '0, '0, '0, '0, '0);
        wait_idle();

        idle_pct = 27;
        set_regs(16'd300, 8'd5, 8'd3, 8'd255);
        add_random(40);
        wait_idle();

        idle_pct = 60;
        set_regs(16'd4, 8'd2, 8'd1, 8'd7);
        add_random(40);
        wait_idle();

        idle_pct = 0;
        set_regs(16'd65535, 8'd255, 8'd255, 8'd128);
        add_random(35);
        wait_idle();

        idle_pct = 0;
        set_regs(16'd1, 8'd1, 8'd2, 8'd255);
        add_random(35);
        wait_idle();

        $display("summary: %0d commands accepted, %0d results checked", accepted, checked);
        $display("five register settings, sender idling at 27, 60 and 0 percent");
        if (errors == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> files.f
hdl/mrt_pkg.sv
hdl/mrt_cell.sv
hdl/mesh_route_table.sv
tb/mesh_route_table_test.sv
